[sv/itp_pkg.sv]
`default_nettype none
package itp_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       out_valid;
    logic       expr_done;
    logic [1:0] error;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    CODE_NONE  = 3'd0,
    CODE_LPAR  = 3'd1,
    CODE_PLUS  = 3'd2,
    CODE_MINUS = 3'd3,
    CODE_STAR  = 3'd4,
    CODE_CARET = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    K_OTHER,
    K_ALNUM,
    K_OP,
    K_LPAR,
    K_RPAR,
    K_FLUSH
  } kind_t;

  typedef enum logic [1:0] {
    SEL_SYM,
    SEL_TOP,
    SEL_MARK
  } emit_sel_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       push;
    logic       pop;
    logic       emit;
    emit_sel_t  emit_sel;
    logic       emit_done;
    logic [1:0] emit_err;
    logic       emit_last;
  } itp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  more;       // at least two entries stacked
    logic  top_lpar;
    logic  top_pops;   // top operator outranks or ties the item
    logic  next_lpar;  // entry under the top is '('
    logic  next_pops;  // entry under the top outranks or ties the item
    logic  can_emit;
  } itp_stat_t;

  function automatic op_code_t op_code(input logic [7:0] c);
    case (c)
      CH_PLUS:  op_code = CODE_PLUS;
      CH_MINUS: op_code = CODE_MINUS;
      CH_STAR:  op_code = CODE_STAR;
      CH_CARET: op_code = CODE_CARET;
      default:  op_code = CODE_NONE;
    endcase
  endfunction

  function automatic logic [1:0] code_prio(input op_code_t c);
    case (c)
      CODE_PLUS:  code_prio = 2'd1;
      CODE_MINUS: code_prio = 2'd1;
      CODE_STAR:  code_prio = 2'd2;
      CODE_CARET: code_prio = 2'd3;
      default:    code_prio = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input op_code_t c);
    case (c)
      CODE_LPAR:  code_char = CH_LPAR;
      CODE_PLUS:  code_char = CH_PLUS;
      CODE_MINUS: code_char = CH_MINUS;
      CODE_STAR:  code_char = CH_STAR;
      CODE_CARET: code_char = CH_CARET;
      default:    code_char = 8'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[sv/itp_datapath.sv]
`default_nettype none
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire itp_cmd_t  cmd,
  output itp_stat_t      stat,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  in_item_t          item_r;
  op_code_t          stack_r [STACK_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  kind_t      kind;
  op_code_t   item_code;
  logic [1:0] item_prio;
  logic       alnum;

  always_comb begin
    alnum = (item_r.symbol >= 8'h30 && item_r.symbol <= 8'h39) ||
            (item_r.symbol >= 8'h41 && item_r.symbol <= 8'h5A) ||
            (item_r.symbol >= 8'h61 && item_r.symbol <= 8'h7A);
    if (item_r.flush) begin
      kind = K_FLUSH;
    end else if (alnum) begin
      kind = K_ALNUM;
    end else if (op_code(item_r.symbol) != CODE_NONE) begin
      kind = K_OP;
    end else if (item_r.symbol == CH_LPAR) begin
      kind = K_LPAR;
    end else if (item_r.symbol == CH_RPAR) begin
      kind = K_RPAR;
    end else begin
      kind = K_OTHER;
    end
    item_code = (kind == K_LPAR) ? CODE_LPAR : op_code(item_r.symbol);
    item_prio = code_prio(item_code);
  end

  always_comb begin
    stat.kind      = kind;
    stat.empty     = (count_r == '0);
    stat.full      = (count_r == CNT_W'(STACK_DEPTH));
    stat.more      = (count_r > CNT_W'(1));
    stat.top_lpar  = (stack_r[0] == CODE_LPAR);
    stat.top_pops  = !stat.empty && (stack_r[0] != CODE_LPAR) &&
                     (code_prio(stack_r[0]) >= item_prio);
    stat.next_lpar = stat.more && (stack_r[1] == CODE_LPAR);
    stat.next_pops = stat.more && (stack_r[1] != CODE_LPAR) &&
                     (code_prio(stack_r[1]) >= item_prio);
    stat.can_emit  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // Shift-register stack: entry 0 is the top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_r[0] <= item_code;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        SEL_SYM:  out_data_r.out_symbol <= item_r.symbol;
        SEL_TOP:  out_data_r.out_symbol <= code_char(stack_r[0]);
        default:  out_data_r.out_symbol <= 8'd0;
      endcase
      out_data_r.out_valid <= (cmd.emit_sel != SEL_MARK);
      out_data_r.expr_done <= cmd.emit_done;
      out_data_r.error     <= cmd.emit_err;
      out_data_r.last      <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/itp_ctrl.sv]
`default_nettype none
module itp_ctrl
  import itp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire itp_stat_t stat,
  output itp_cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t state_r, state_nxt;
  logic   lerr_r, lerr_nxt;  // '(' dropped during flush
  logic   finish;

  always_comb begin
    cmd           = '0;
    cmd.emit_sel  = SEL_MARK;
    cmd.emit_err  = ERR_NONE;
    cmd.load_item = (state_r == S_IDLE) && in_valid;
    finish        = 1'b0;
    lerr_nxt      = lerr_r;
    state_nxt     = state_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (stat.can_emit) begin
          case (stat.kind)
            K_FLUSH: begin
              if (stat.empty) begin
                cmd.emit      = 1'b1;
                cmd.emit_done = 1'b1;
                cmd.emit_err  = lerr_r ? ERR_PAREN : ERR_NONE;
                cmd.emit_last = 1'b1;
                lerr_nxt      = 1'b0;
                finish        = 1'b1;
              end else begin
                cmd.pop = 1'b1;
                if (stat.top_lpar) begin
                  lerr_nxt = 1'b1;
                end else begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = SEL_TOP;
                end
              end
            end
            K_ALNUM: begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = SEL_SYM;
              cmd.emit_last = 1'b1;
              finish        = 1'b1;
            end
            K_OP, K_LPAR: begin
              if (stat.kind == K_OP && stat.top_pops) begin
                // last pop unless the entry below pops too
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_TOP;
                cmd.pop       = 1'b1;
                cmd.emit_last = !stat.next_pops;
              end else if (stat.full) begin
                cmd.emit      = 1'b1;
                cmd.emit_err  = ERR_OVERFLOW;
                cmd.emit_last = 1'b1;
                finish        = 1'b1;
              end else begin
                cmd.push = 1'b1;
                finish   = 1'b1;
              end
            end
            K_RPAR: begin
              if (stat.empty) begin
                cmd.emit      = 1'b1;
                cmd.emit_err  = ERR_PAREN;
                cmd.emit_last = 1'b1;
                finish        = 1'b1;
              end else if (stat.top_lpar) begin
                cmd.pop = 1'b1;
                finish  = 1'b1;
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = SEL_TOP;
                cmd.pop       = 1'b1;
                cmd.emit_last = stat.next_lpar;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lerr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lerr_r  <= lerr_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

[sv/infix_to_postfix_converter.sv]
`default_nettype none
// Channel  | Ports                             | Direction | Carries
// input    | in_valid, in_stall, in_data       | in        | one character or end flush
// result   | out_valid, out_stall, out_data    | out       | one postfix character or marker
//
// Steps: an item is taken while idle, then worked one step at a time. A step pops
//   one entry, emits one result, or does both; the last step also pushes or
//   finishes. in_stall holds off the next item until the current one is done;
//   a flush pops each stacked entry in turn.
// Reset: synchronous, active low; clears the stack count, controller state
//   and the output register's valid. Stack entries are not cleared.
// Stalls: out_stall freezes all work until the held result is taken; the
//   output register lets a finished item's last result wait while the next
//   item is taken.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  itp_cmd_t  cmd;
  itp_stat_t stat;

  // Sequence the item: decide pop, push and emit one step at a time
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the item, the operator stack and the output register
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import itp_pkg::*;

  localparam int STACK_N = 16;

  // Scoreboard: mirrors the operator stack and queues the postfix results
  // that each accepted character is expected to produce.
  class postfix_scoreboard;
    op_code_t  opstack[STACK_N];
    int        depth;
    out_item_t expected_q[$];
    out_item_t staged[$];
    int        mismatches;
    int        results_checked;
    int        exprs_closed;
    int        paren_marks;
    int        overflow_marks;

    function new();
      depth = 0;
      mismatches = 0;
      results_checked = 0;
      exprs_closed = 0;
      paren_marks = 0;
      overflow_marks = 0;
    endfunction

    function logic [1:0] rank(op_code_t c);
      case (c)
        CODE_PLUS, CODE_MINUS: return 2'd1;
        CODE_STAR:             return 2'd2;
        CODE_CARET:            return 2'd3;
        default:               return 2'd0;
      endcase
    endfunction

    function logic [7:0] glyph(op_code_t c);
      case (c)
        CODE_PLUS:  return CH_PLUS;
        CODE_MINUS: return CH_MINUS;
        CODE_STAR:  return CH_STAR;
        CODE_CARET: return CH_CARET;
        default:    return 8'h00;
      endcase
    endfunction

    function op_code_t classify_op(logic [7:0] c);
      case (c)
        CH_PLUS:  return CODE_PLUS;
        CH_MINUS: return CODE_MINUS;
        CH_STAR:  return CODE_STAR;
        CH_CARET: return CODE_CARET;
        default:  return CODE_NONE;
      endcase
    endfunction

    function bit is_operand(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function void stage(logic [7:0] sym, logic valid, logic done, logic [1:0] err);
      out_item_t r;
      r.out_symbol = sym;
      r.out_valid  = valid;
      r.expr_done  = done;
      r.error      = err;
      r.last       = 1'b0;
      if (err == ERR_PAREN) paren_marks++;
      if (err == ERR_OVERFLOW) overflow_marks++;
      if (done) exprs_closed++;
      staged.push_back(r);
    endfunction

    function void push_code(op_code_t c);
      if (depth >= STACK_N) begin
        stage(8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
      end else begin
        opstack[depth] = c;
        depth++;
      end
    endfunction

    // Returns 1 when the character does something, 0 when the block drops it.
    function bit note_input(in_item_t it);
      op_code_t   code;
      op_code_t   t;
      logic [1:0] err;
      bit         found;
      bit         active;
      out_item_t  r;
      active = 1'b1;
      if (it.flush) begin
        err = ERR_NONE;
        while (depth > 0) begin
          t = opstack[depth-1];
          depth--;
          if (t == CODE_LPAR) err = ERR_PAREN;
          else stage(glyph(t), 1'b1, 1'b0, ERR_NONE);
        end
        stage(8'h00, 1'b0, 1'b1, err);
      end else if (is_operand(it.symbol)) begin
        stage(it.symbol, 1'b1, 1'b0, ERR_NONE);
      end else begin
        code = classify_op(it.symbol);
        if (code != CODE_NONE) begin
          // Pop everything that ties or outranks, stop at '('
          while (depth > 0) begin
            t = opstack[depth-1];
            if (t == CODE_LPAR || rank(t) < rank(code)) break;
            stage(glyph(t), 1'b1, 1'b0, ERR_NONE);
            depth--;
          end
          push_code(code);
        end else if (it.symbol == CH_LPAR) begin
          push_code(CODE_LPAR);
        end else if (it.symbol == CH_RPAR) begin
          found = 1'b0;
          while (depth > 0) begin
            t = opstack[depth-1];
            depth--;
            if (t == CODE_LPAR) begin
              found = 1'b1;
              break;
            end
            stage(glyph(t), 1'b1, 1'b0, ERR_NONE);
          end
          if (!found) stage(8'h00, 1'b0, 1'b0, ERR_PAREN);
        end else begin
          active = 1'b0;
        end
      end
      if (staged.size() > 0) begin
        r = staged[staged.size()-1];
        r.last = 1'b1;
        staged[staged.size()-1] = r;
      end
      foreach (staged[i]) expected_q.push_back(staged[i]);
      staged.delete();
      return active;
    endfunction

    function void report(string what, out_item_t exp_r, out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $time, what);
        $display("  exp sym=%02h v=%0b done=%0b err=%0d last=%0b", exp_r.out_symbol,
                 exp_r.out_valid, exp_r.expr_done, exp_r.error, exp_r.last);
        $display("  got sym=%02h v=%0b done=%0b err=%0d last=%0b", got.out_symbol,
                 got.out_valid, got.expr_done, got.error, got.last);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      bit        bad;
      results_checked++;
      if (expected_q.size() == 0) begin
        exp_r = '0;
        report("result with nothing expected", exp_r, got);
        return;
      end
      exp_r = expected_q.pop_front();
      bad = (got.out_symbol !== exp_r.out_symbol) || (got.out_valid !== exp_r.out_valid) ||
            (got.expr_done !== exp_r.expr_done) || (got.error !== exp_r.error) ||
            (got.last !== exp_r.last);
      if (bad) report("result mismatch", exp_r, got);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  postfix_scoreboard sb;

  int burst_left;
  int accepted;
  int active_items;
  int stall_tick = 0;
  int stall_mode = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_N)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("[infix_to_postfix_converter] ERROR");
    $finish;
  end

  // Receiver: stall_mode, redrawn at random as stall_tick counts, selects no stall,
  // light random stall, a periodic stall or heavy random stall.
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 150 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= (stall_tick % 4 != 0);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Check every result taken at this edge (values sampled before the edge).
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  // Hand one item to the block; open a new burst after a random gap when
  // the current burst runs out. Return at the edge that takes the item.
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    accepted++;
    if (sb.note_input(item)) active_items++;
    burst_left--;
  endtask

  task automatic send_sym(input logic [7:0] sym);
    in_item_t it;
    it.symbol = sym;
    it.flush  = 1'b0;
    send_item(it);
  endtask

  // Close the expression; the symbol rides along and must be ignored.
  task automatic send_flush(input logic [7:0] sym);
    in_item_t it;
    it.symbol = sym;
    it.flush  = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_sym(s[i]);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));   // digit
      1:       return 8'h41 + 8'($urandom_range(0, 25));  // upper case
      default: return 8'h61 + 8'($urandom_range(0, 25));  // lower case
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_CARET;
    endcase
  endfunction

  // Well-formed expression with random nesting, closed by a flush.
  task automatic send_expression();
    int terms;
    int open;
    terms = $urandom_range(1, 7);
    open  = 0;
    for (int i = 0; i < terms; i++) begin
      while (open < 6 && $urandom_range(0, 3) == 0) begin
        send_sym(CH_LPAR);
        open++;
      end
      send_sym(rand_operand());
      // a stray blank now and then: the block must drop it
      if ($urandom_range(0, 9) == 0) send_sym(8'h20);
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        send_sym(CH_RPAR);
        open--;
      end
      if (i < terms - 1) send_sym(rand_operator());
    end
    while (open > 0) begin
      send_sym(CH_RPAR);
      open--;
    end
    send_flush(8'($urandom_range(0, 255)));
  endtask

  // Nest close to the stack depth or push past it, then unwind partly and flush.
  task automatic send_deep_nest();
    int k;
    k = $urandom_range(14, 20);
    repeat (k) begin
      if ($urandom_range(0, 3) == 0) begin
        send_sym(rand_operand());
        send_sym(rand_operator());
      end
      send_sym(CH_LPAR);
    end
    repeat ($urandom_range(1, 3)) send_sym(rand_operator());
    send_sym(rand_operand());
    repeat ($urandom_range(0, k)) send_sym(CH_RPAR);
    send_flush(8'($urandom_range(0, 255)));
  endtask

  // Arbitrary bytes, including the whole 8-bit range.
  task automatic send_noise();
    repeat ($urandom_range(1, 5)) send_sym(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0) send_flush(8'($urandom_range(0, 255)));
  endtask

  // Random mix of expression characters with no grammar at all.
  task automatic send_broken();
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(0, 7))
        0, 1:    send_sym(rand_operand());
        2, 3, 4: send_sym(rand_operator());
        5:       send_sym(CH_LPAR);
        6:       send_sym(CH_RPAR);
        default: send_sym(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) send_flush(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int pick;
    int guard;
    sb = new();
    burst_left   = 0;
    accepted     = 0;
    active_items = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all operand classes, every operator and both parens, bytes
    // at both ends of the range, a flush that carries a nonzero symbol,
    // ')' on an empty stack, ')' with no '(' below operators, '(' left
    // open at the flush, and a flush on an empty stack.
    send_text("(A+9)*z^0-a");
    send_flush(8'hFF);
    send_sym(8'h00);
    send_sym(8'hFF);
    send_text(")a+b)(");
    send_flush(8'h00);
    send_flush(8'h5A);

    // Random: mostly well-formed expressions, then stack fills, noise and
    // broken sequences.
    while (accepted < 340) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_expression();
      else if (pick < 80) send_deep_nest();
      else if (pick < 90) send_noise();
      else                send_broken();
    end
    in_valid <= 1'b0;

    // Drain: wait for every queued result, then a margin for stray output.
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("Ran %0d characters (%0d not ignored), checked %0d results.",
             accepted, active_items, sb.results_checked);
    $display("Closed %0d expressions; %0d paren error marks, %0d overflow marks.",
             sb.exprs_closed, sb.paren_marks, sb.overflow_marks);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[infix_to_postfix_converter] OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches,
               sb.expected_q.size());
      $display("[infix_to_postfix_converter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[infix_to_postfix_converter.f]
sv/itp_pkg.sv
sv/itp_datapath.sv
sv/itp_ctrl.sv
sv/infix_to_postfix_converter.sv
test/tb.sv
